@@ rtl/flash_image_ingest_crc32_macros.svh @@
// Assertion helpers shared by the ingest block.
`ifndef FLASH_IMAGE_INGEST_CRC32_MACROS_SVH
`define FLASH_IMAGE_INGEST_CRC32_MACROS_SVH

`ifndef NO_ASSERTIONS

`define FIIC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fiic: same-cycle check failed");

`define FIIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fiic: next-cycle check failed");

`else

`define FIIC_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define FIIC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/fiic_pkg.sv @@
package fiic_pkg;

    localparam int SIZE_BITS      = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    // job queue between the front and the back; depth is a power of two
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [7:0]  PAD_BYTE = 8'hFF;

    localparam logic [31:0]          RST_BACKUP_BASE     = 32'h0808_0000;
    localparam logic [SIZE_BITS-1:0] RST_BACKUP_CAPACITY = 24'h06_0000;
    localparam logic [31:0]          RST_FLAG_ADDRESS    = 32'h0801_0000;
    localparam logic [31:0]          RST_FLAG_MAGIC      = 32'h0000_0000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BACKUP_BASE     = 2'd0,
        CFG_BACKUP_CAPACITY = 2'd1,
        CFG_FLAG_ADDRESS    = 2'd2,
        CFG_FLAG_MAGIC      = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        OP_START  = 3'd0,
        OP_DATA   = 3'd1,
        OP_FINISH = 3'd2,
        OP_STOP   = 3'd3,
        OP_FAULT  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        CMD_STATUS  = 3'd0,
        CMD_ERASE   = 3'd1,
        CMD_PROGRAM = 3'd2,
        CMD_RETAIN  = 3'd3,
        CMD_RESET   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK            = 3'd0,
        STS_REJECTED      = 3'd1,
        STS_PAD_DROP      = 3'd2,
        STS_SIZE_MISMATCH = 3'd3,
        STS_NOT_RECV      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RECV = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    // result steps of one job, in emission order
    typedef enum logic [2:0] {
        STEP_ERASE_W    = 3'd0,
        STEP_PROG_W     = 3'd1,
        STEP_FLAG_ERASE = 3'd2,
        STEP_FLAG_MAGIC = 3'd3,
        STEP_FLAG_SIZE  = 3'd4,
        STEP_FLAG_CRC   = 3'd5,
        STEP_RETAIN     = 3'd6,
        STEP_RESET      = 3'd7
    } t_step;

    typedef struct packed {
        logic [2:0]           operation;
        logic [SIZE_BITS-1:0] declared_size;
        logic [7:0]           data_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]           command;
        logic [31:0]          flash_address;
        logic [31:0]          flash_word;
        logic [2:0]           status;
        logic [1:0]           phase;
        logic [SIZE_BITS-1:0] received_count;
        logic                 last;
    } t_out;

    typedef struct packed {
        logic                 erase;
        logic                 word_en;
        logic                 flag_en;
        logic [31:0]          addr;
        logic [31:0]          word;
        logic [SIZE_BITS-1:0] size;
        logic [31:0]          crc;
        t_status              status;
        t_phase               phase;
        logic [SIZE_BITS-1:0] count;
    } t_job;

endpackage

@@ rtl/fiic_secmod.sv @@
module fiic_secmod #(
    parameter int SECTOR_BYTES = 131072
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_addr,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_limit
);

    localparam int RB     = $clog2(SECTOR_BYTES);
    localparam int XB     = RB + 4;
    localparam int NIB    = 8;
    localparam int SB     = $clog2(NIB + 1);
    localparam logic [XB-1:0] SEC      = XB'(SECTOR_BYTES);
    localparam logic [SB-1:0] LAST_STEP = SB'(NIB);

    logic          r_busy;
    logic [SB-1:0] r_step;
    logic [RB-1:0] r_rem;
    logic [31:0]   r_sh;
    logic [31:0]   r_addr;
    logic [RB-1:0] n_rem;
    logic [XB-1:0] w_acc;

    // one nibble a step: acc = rem * 16 + nibble, then reduce below the sector size
    always_comb begin
        w_acc = {r_rem, r_sh[31:28]};
        for (int k = 3; k >= 0; k--) begin
            if (w_acc >= (SEC << k)) begin
                w_acc = w_acc - (SEC << k);
            end
        end
        n_rem = w_acc[RB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            if (r_step == LAST_STEP) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_sh   <= i_addr;
            r_addr <= i_addr;
        end else if (r_busy && r_step != LAST_STEP) begin
            r_rem <= n_rem;
            r_sh  <= {r_sh[27:0], 4'd0};
        end
    end

    assign o_busy  = r_busy;
    assign o_done  = r_busy && (r_step == LAST_STEP);
    assign o_limit = r_addr - 32'(r_rem) + 32'(SECTOR_BYTES);

endmodule

@@ rtl/fiic_front.sv @@
`include "flash_image_ingest_crc32_macros.svh"

module fiic_front #(
    parameter int SECTOR_BYTES = 131072
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  fiic_pkg::t_in                  i_data,
    input  logic [31:0]                    i_backup_base,
    input  logic [fiic_pkg::SIZE_BITS-1:0] i_backup_capacity,
    input  logic                           i_q_full,
    output logic                           o_push,
    output fiic_pkg::t_job                 o_job
);

    localparam int SB = fiic_pkg::SIZE_BITS;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ fiic_pkg::CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    fiic_pkg::t_phase r_phase, n_phase;
    logic [SB-1:0]    r_exp, n_exp;
    logic [SB-1:0]    r_count, n_count;
    logic [31:0]      r_crc, n_crc;
    logic [31:0]      r_limit, n_limit;
    logic [23:0]      r_pend, n_pend;
    logic [1:0]       r_pend_cnt, n_pend_cnt;

    logic        w_accept;
    logic [31:0] w_addr;
    logic        w_erase;
    logic [31:0] w_crc_next;
    logic [31:0] w_tail;
    logic        w_clear;
    logic        w_mod_start;
    logic        w_mod_busy;
    logic        w_mod_done;
    logic [31:0] w_mod_limit;
    logic        w_data_ok;

    fiic_secmod #(
        .SECTOR_BYTES(SECTOR_BYTES)
    ) u_secmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_addr  (w_addr),
        .o_busy  (w_mod_busy),
        .o_done  (w_mod_done),
        .o_limit (w_mod_limit)
    );

    // hold requests while the queue is full or the next sector limit is pending
    assign o_stall  = i_q_full || w_mod_busy;
    assign w_accept = i_valid && !o_stall;
    assign o_push   = w_accept;

    assign w_addr     = i_backup_base + 32'({r_count[SB-1:2], 2'b00});
    assign w_erase    = (w_addr >= r_limit);
    assign w_crc_next = crc_byte(r_crc, i_data.data_byte);

    always_comb begin
        w_tail = {fiic_pkg::PAD_BYTE, r_pend};
        for (int i = 0; i < 3; i++) begin
            if (2'(i) >= r_pend_cnt) begin
                w_tail[8*i +: 8] = fiic_pkg::PAD_BYTE;
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_exp       = r_exp;
        n_count     = r_count;
        n_crc       = r_crc;
        n_limit     = r_limit;
        n_pend      = r_pend;
        n_pend_cnt  = r_pend_cnt;
        w_clear     = 1'b0;
        w_mod_start = 1'b0;
        w_data_ok   = 1'b0;

        o_job         = '0;
        o_job.addr    = w_addr;
        o_job.size    = r_exp;
        o_job.crc     = ~r_crc;
        o_job.status  = fiic_pkg::STS_OK;

        unique case (i_data.operation)
            fiic_pkg::OP_START: begin
                if (i_data.declared_size == '0 || i_data.declared_size > i_backup_capacity) begin
                    o_job.status = fiic_pkg::STS_REJECTED;
                end else begin
                    n_exp      = i_data.declared_size;
                    n_count    = '0;
                    n_crc      = fiic_pkg::CRC_INIT;
                    n_pend     = '0;
                    n_pend_cnt = '0;
                    n_limit    = i_backup_base;
                    n_phase    = fiic_pkg::PH_RECV;
                end
            end
            fiic_pkg::OP_DATA: begin
                if (r_phase != fiic_pkg::PH_RECV) begin
                    o_job.status = fiic_pkg::STS_NOT_RECV;
                end else if (r_count >= r_exp) begin
                    o_job.status = fiic_pkg::STS_PAD_DROP;
                end else begin
                    w_data_ok = w_accept;
                    n_crc     = w_crc_next;
                    if (r_pend_cnt == 2'd3) begin
                        o_job.word_en = 1'b1;
                        o_job.erase   = w_erase;
                        o_job.word    = {i_data.data_byte, r_pend};
                        w_mod_start   = w_accept && w_erase;
                        n_pend        = '0;
                        n_pend_cnt    = '0;
                    end else begin
                        n_pend     = r_pend | (24'(i_data.data_byte) << {r_pend_cnt, 3'b000});
                        n_pend_cnt = r_pend_cnt + 2'd1;
                    end
                    n_count = r_count + 1'b1;
                end
            end
            fiic_pkg::OP_FINISH: begin
                if (r_phase != fiic_pkg::PH_RECV) begin
                    w_clear      = 1'b1;
                    o_job.status = fiic_pkg::STS_NOT_RECV;
                end else begin
                    if (r_pend_cnt != 2'd0) begin
                        o_job.word_en = 1'b1;
                        o_job.erase   = w_erase;
                        o_job.word    = w_tail;
                        n_pend        = '0;
                        n_pend_cnt    = '0;
                    end
                    if (r_count != r_exp) begin
                        w_clear      = 1'b1;
                        o_job.status = fiic_pkg::STS_SIZE_MISMATCH;
                    end else begin
                        o_job.flag_en = 1'b1;
                        n_phase       = fiic_pkg::PH_DONE;
                    end
                end
            end
            fiic_pkg::OP_STOP: begin
                w_clear = 1'b1;
            end
            fiic_pkg::OP_FAULT: begin
                w_clear      = 1'b1;
                o_job.status = fiic_pkg::STS_REJECTED;
            end
            default: begin
                o_job.status = fiic_pkg::STS_REJECTED;
            end
        endcase

        if (w_clear) begin
            n_phase    = fiic_pkg::PH_IDLE;
            n_exp      = '0;
            n_count    = '0;
            n_crc      = '0;
            n_limit    = '0;
            n_pend     = '0;
            n_pend_cnt = '0;
        end

        o_job.phase = n_phase;
        o_job.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= fiic_pkg::PH_IDLE;
            r_exp      <= '0;
            r_count    <= '0;
            r_crc      <= '0;
            r_limit    <= '0;
            r_pend     <= '0;
            r_pend_cnt <= '0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_exp      <= n_exp;
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_limit    <= n_limit;
            r_pend     <= n_pend;
            r_pend_cnt <= n_pend_cnt;
        end else if (w_mod_done) begin
            r_limit <= w_mod_limit;
        end
    end

    `FIIC_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, w_data_ok, r_count == $past(r_count) + 1'b1)
    `FIIC_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, r_phase == fiic_pkg::PH_RECV, r_count <= r_exp)
    `FIIC_ASSERT_IMP(a_pack_align, i_clk, i_rst_n, r_phase == fiic_pkg::PH_RECV, r_pend_cnt == r_count[1:0])

endmodule

@@ rtl/fiic_queue.sv @@
`include "flash_image_ingest_crc32_macros.svh"

module fiic_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fiic_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output fiic_pkg::t_job o_job
);

    localparam int PB = fiic_pkg::QPTR_BITS;
    localparam logic [PB:0] FULL_CNT = (PB + 1)'(fiic_pkg::QDEPTH);

    fiic_pkg::t_job r_mem [fiic_pkg::QDEPTH];
    logic [PB-1:0]  r_wr;
    logic [PB-1:0]  r_rd;
    logic [PB:0]    r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PB + 1)'(i_push) - (PB + 1)'(i_pop);
        end
    end

    `FIIC_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `FIIC_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)

endmodule

@@ rtl/fiic_back.sv @@
module fiic_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fiic_pkg::t_job i_job,
    input  logic           i_empty,
    output logic           o_pop,
    input  logic [31:0]    i_flag_address,
    input  logic [31:0]    i_flag_magic,
    output logic           o_valid,
    input  logic           i_stall,
    output fiic_pkg::t_out o_data
);

    fiic_pkg::t_step r_step, n_step;
    logic            r_valid;
    fiic_pkg::t_out  r_out;

    logic [7:0]      w_mask;
    logic [7:0]      w_elig;
    logic [2:0]      w_cur;
    logic            w_found;
    logic            w_more;
    logic            w_last;
    logic            w_load;
    fiic_pkg::t_out  w_res;

    always_comb begin
        w_mask = {{6{i_job.flag_en}}, i_job.word_en, i_job.erase};
        for (int i = 0; i < 8; i++) begin
            w_elig[i] = w_mask[i] && (3'(i) >= r_step);
        end

        w_cur   = '0;
        w_found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (w_elig[i] && !w_found) begin
                w_cur   = 3'(i);
                w_found = 1'b1;
            end
        end

        w_more = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (w_elig[i] && 3'(i) > w_cur) begin
                w_more = 1'b1;
            end
        end
        w_last = !w_more;

        // advance when the output register is free or being taken
        w_load = !i_empty && (!r_valid || !i_stall);
        o_pop  = w_load && w_last;

        w_res                = '0;
        w_res.status         = i_job.status;
        w_res.phase          = i_job.phase;
        w_res.received_count = i_job.count;
        w_res.last           = w_last;
        w_res.command        = fiic_pkg::CMD_STATUS;

        if (w_found) begin
            unique case (fiic_pkg::t_step'(w_cur))
                fiic_pkg::STEP_ERASE_W: begin
                    w_res.command       = fiic_pkg::CMD_ERASE;
                    w_res.flash_address = i_job.addr;
                end
                fiic_pkg::STEP_PROG_W: begin
                    w_res.command       = fiic_pkg::CMD_PROGRAM;
                    w_res.flash_address = i_job.addr;
                    w_res.flash_word    = i_job.word;
                end
                fiic_pkg::STEP_FLAG_ERASE: begin
                    w_res.command       = fiic_pkg::CMD_ERASE;
                    w_res.flash_address = i_flag_address;
                end
                fiic_pkg::STEP_FLAG_MAGIC: begin
                    w_res.command       = fiic_pkg::CMD_PROGRAM;
                    w_res.flash_address = i_flag_address;
                    w_res.flash_word    = i_flag_magic;
                end
                fiic_pkg::STEP_FLAG_SIZE: begin
                    w_res.command       = fiic_pkg::CMD_PROGRAM;
                    w_res.flash_address = i_flag_address + 32'd4;
                    w_res.flash_word    = 32'(i_job.size);
                end
                fiic_pkg::STEP_FLAG_CRC: begin
                    w_res.command       = fiic_pkg::CMD_PROGRAM;
                    w_res.flash_address = i_flag_address + 32'd8;
                    w_res.flash_word    = i_job.crc;
                end
                fiic_pkg::STEP_RETAIN: begin
                    w_res.command    = fiic_pkg::CMD_RETAIN;
                    w_res.flash_word = i_flag_magic;
                end
                fiic_pkg::STEP_RESET: begin
                    w_res.command = fiic_pkg::CMD_RESET;
                end
                default: begin
                    w_res.command = fiic_pkg::CMD_STATUS;
                end
            endcase
        end

        n_step = r_step;
        if (w_load) begin
            n_step = w_last ? fiic_pkg::STEP_ERASE_W : fiic_pkg::t_step'(w_cur + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= fiic_pkg::STEP_ERASE_W;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

endmodule

@@ rtl/flash_image_ingest_crc32.sv @@
// Firmware image ingest: CRC-32 over the image and flash erase/program command stream.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries start, data byte, finish,
// stop and flash fault requests. Output channel (o_out_valid / i_out_stall / o_out_data)
// gives one to eight results per request, the final one marked by last.
// Configuration registers are written through i_cfg_we / i_cfg_index / i_cfg_data.
// The user must write them only while no request is in flight; the block does not check.
// A request is stored in the job queue and its first result then in the output register.
// Throughput: one request per cycle when each produces one result and nothing stalls.
// The result sequencer gives one result per cycle while the receiver does not stall, so
// a request with several results occupies it for each; a four-entry job queue lets the
// input run ahead. A programmed word that opens a new flash sector holds the input
// while the sector remainder unit (4 address bits a cycle) sets the next erase limit.
// Reset (synchronous, active low) restores the register defaults, returns the
// download state to idle and empties the queue and output register.
// When the receiver stalls, the output result holds; the queue fills and then the
// input side stalls too.
module flash_image_ingest_crc32 #(
    parameter int SECTOR_BYTES = 131072
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fiic_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fiic_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_we,
    input  logic [fiic_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [fiic_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic [31:0]                    r_backup_base;
    logic [fiic_pkg::SIZE_BITS-1:0] r_backup_capacity;
    logic [31:0]                    r_flag_address;
    logic [31:0]                    r_flag_magic;

    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    fiic_pkg::t_job w_job_in;
    fiic_pkg::t_job w_job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backup_base     <= fiic_pkg::RST_BACKUP_BASE;
            r_backup_capacity <= fiic_pkg::RST_BACKUP_CAPACITY;
            r_flag_address    <= fiic_pkg::RST_FLAG_ADDRESS;
            r_flag_magic      <= fiic_pkg::RST_FLAG_MAGIC;
        end else if (i_cfg_we) begin
            unique case (fiic_pkg::t_cfg_index'(i_cfg_index))
                fiic_pkg::CFG_BACKUP_BASE:     r_backup_base <= i_cfg_data;
                fiic_pkg::CFG_BACKUP_CAPACITY: begin
                    r_backup_capacity <= i_cfg_data[fiic_pkg::SIZE_BITS-1:0];
                end
                fiic_pkg::CFG_FLAG_ADDRESS:    r_flag_address <= i_cfg_data;
                fiic_pkg::CFG_FLAG_MAGIC:      r_flag_magic <= i_cfg_data;
                default: begin
                    r_flag_magic <= r_flag_magic;
                end
            endcase
        end
    end

    fiic_front #(
        .SECTOR_BYTES(SECTOR_BYTES)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_in_valid),
        .o_stall           (o_in_stall),
        .i_data            (i_in_data),
        .i_backup_base     (r_backup_base),
        .i_backup_capacity (r_backup_capacity),
        .i_q_full          (w_full),
        .o_push            (w_push),
        .o_job             (w_job_in)
    );

    fiic_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_job_out)
    );

    fiic_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (w_job_out),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .i_flag_address (r_flag_address),
        .i_flag_magic   (r_flag_magic),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_data         (o_out_data)
    );

endmodule
